[src/bsde_pkg.sv]
`default_nettype none

package bsde_pkg;

  // Payload length and position width; the largest payload is all ones in this width.
  localparam int unsigned LenW = 11;
  localparam logic [LenW-1:0] MAX_PAYLOAD_BYTES = 11'd2047;

  // Shortest payload that is walked at all
  localparam logic [LenW-1:0] MIN_WALK_LEN = 11'd5;

  // Element header: type, uuid low, uuid high, app code, one skipped byte
  localparam logic [7:0] MIN_TARGET_LEN = 8'd5;
  localparam logic [7:0] HDR_BYTES      = 8'd5;
  localparam logic [7:0] FIRST_MSG_OFF  = 8'd6;

  // Configuration register reset values
  localparam logic [7:0]  ELEMENT_TYPE_RST     = 8'h16;
  localparam logic [15:0] SERVICE_UUID_RST     = 16'hFFFA;
  localparam logic [7:0]  APPLICATION_CODE_RST = 8'h0D;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ELEMENT_TYPE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SERVICE_UUID     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_APPLICATION_CODE = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Result kinds
  localparam logic [1:0] KIND_MSG_BYTE   = 2'd0;
  localparam logic [1:0] KIND_EMPTY_MSG  = 2'd1;
  localparam logic [1:0] KIND_NO_MATCH   = 2'd2;

  // Offsets of the header bytes inside an element
  localparam logic [7:0] OFF_TYPE     = 8'd1;
  localparam logic [7:0] OFF_UUID_LO  = 8'd2;
  localparam logic [7:0] OFF_UUID_HI  = 8'd3;
  localparam logic [7:0] OFF_APP_CODE = 8'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] msg_byte;
    logic [7:0] msg_index;
    logic [7:0] msg_length;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

[src/ble_service_data_extractor.sv]
// The walk and header compare are a single pass, and a result is registered in the output
// register. Throughput: one input transaction per cycle while in_stall_o is low.
// A two-entry output (result register plus skid register) keeps the input open while a
// result waits; input stalls only when both entries hold results.
// Reset (rst_ni low, async): walk state cleared, as at the start of a payload; config
// registers return to element type 0x16, uuid 0xFFFA, application code 0x0D.
`default_nettype none

module ble_service_data_extractor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [bsde_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bsde_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input channel
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [7:0]                     byte_value_i,
  input  wire logic [bsde_pkg::LenW-1:0]      packet_length_i,
  input  wire logic                           first_of_payload_i,
  // output channel
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [1:0]                     result_kind_o,
  output      logic [7:0]                     message_byte_o,
  output      logic [7:0]                     message_index_o,
  output      logic [7:0]                     message_length_o,
  output      logic                           last_of_run_o
);

  localparam int unsigned LenW = bsde_pkg::LenW;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [7:0]  element_type_q;
  logic [15:0] service_uuid_q;
  logic [7:0]  application_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_type_q     <= bsde_pkg::ELEMENT_TYPE_RST;
      service_uuid_q     <= bsde_pkg::SERVICE_UUID_RST;
      application_code_q <= bsde_pkg::APPLICATION_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bsde_pkg::CFG_ELEMENT_TYPE:     element_type_q     <= cfg_wdata_i[7:0];
        bsde_pkg::CFG_SERVICE_UUID:     service_uuid_q     <= cfg_wdata_i;
        bsde_pkg::CFG_APPLICATION_CODE: application_code_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Walk state
  // ------------------------------------------------------------------
  logic [LenW-1:0] byte_pos_q, byte_pos_d;
  logic [LenW-1:0] next_start_q, next_start_d;
  logic [7:0]      elem_len_q, elem_len_d;
  logic [7:0]      elem_off_q, elem_off_d;
  logic            hdr_match_q, hdr_match_d;
  logic            match_found_q, match_found_d;
  logic            walk_stopped_q, walk_stopped_d;

  logic in_fire;
  logic out_fire;

  // state as seen by this byte: a first byte restarts the walk
  logic [LenW-1:0] pos, nstart;
  logic [7:0]      elen, eoff;
  logic            hm, mf, ws;
  logic [LenW:0]   pos_p1;      // one bit wider, used in compares against the length
  logic [LenW:0]   elem_end;    // pos + 1 + byte, may pass the payload end

  bsde_pkg::result_t res;
  logic              res_valid;

  always_comb begin
    pos    = first_of_payload_i ? '0 : byte_pos_q;
    nstart = first_of_payload_i ? '0 : next_start_q;
    elen   = first_of_payload_i ? '0 : elem_len_q;
    eoff   = first_of_payload_i ? '0 : elem_off_q;
    hm     = first_of_payload_i ? 1'b0 : hdr_match_q;
    mf     = first_of_payload_i ? 1'b0 : match_found_q;
    ws     = first_of_payload_i ? 1'b0 : walk_stopped_q;

    pos_p1   = {1'b0, pos} + {{LenW{1'b0}}, 1'b1};
    elem_end = pos_p1 + {{(LenW-7){1'b0}}, byte_value_i};

    // position counter saturates at the largest payload size
    byte_pos_d     = (pos != bsde_pkg::MAX_PAYLOAD_BYTES) ? pos_p1[LenW-1:0] : pos;
    next_start_d   = nstart;
    elem_len_d     = elen;
    elem_off_d     = eoff;
    hdr_match_d    = hm;
    match_found_d  = mf;
    walk_stopped_d = ws;

    res       = '0;
    res_valid = 1'b0;

    // length field is 11 bits, so it never exceeds the maximum payload: no clamp needed
    if (pos < packet_length_i) begin
      if ((packet_length_i >= bsde_pkg::MIN_WALK_LEN) && !ws && !mf) begin
        if (pos == nstart) begin
          // length byte of a new element
          elem_len_d  = '0;
          elem_off_d  = '0;
          hdr_match_d = 1'b0;
          if (pos_p1 == {1'b0, packet_length_i}) begin
            walk_stopped_d = 1'b1;            // length byte on the final payload byte
          end else if (byte_value_i == 8'd0) begin
            next_start_d = pos_p1[LenW-1:0];  // empty element, skip
          end else if (elem_end > {1'b0, packet_length_i}) begin
            walk_stopped_d = 1'b1;            // element runs past the end
          end else begin
            elem_len_d   = byte_value_i;
            hdr_match_d  = (byte_value_i >= bsde_pkg::MIN_TARGET_LEN);
            next_start_d = elem_end[LenW-1:0];
          end
        end else if ((elen != 8'd0) && (eoff < elen)) begin
          elem_off_d = eoff + 8'd1;
          case (elem_off_d)
            bsde_pkg::OFF_TYPE: hdr_match_d = hm && (byte_value_i == element_type_q);
            bsde_pkg::OFF_UUID_LO: hdr_match_d = hm && (byte_value_i == service_uuid_q[7:0]);
            bsde_pkg::OFF_UUID_HI: hdr_match_d = hm && (byte_value_i == service_uuid_q[15:8]);
            bsde_pkg::OFF_APP_CODE: begin
              hdr_match_d = hm && (byte_value_i == application_code_q);
              if (hdr_match_d) begin
                match_found_d = 1'b1;
                if (elen == bsde_pkg::MIN_TARGET_LEN) begin
                  res_valid = 1'b1;
                  res.kind  = bsde_pkg::KIND_EMPTY_MSG;
                  res.last  = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end else if (mf && (elen != 8'd0) && (eoff < elen)) begin
        // message bytes of the matched element
        elem_off_d = eoff + 8'd1;
        if (elem_off_d >= bsde_pkg::FIRST_MSG_OFF) begin
          res_valid      = 1'b1;
          res.kind       = bsde_pkg::KIND_MSG_BYTE;
          res.msg_byte   = byte_value_i;
          res.msg_index  = elem_off_d - bsde_pkg::FIRST_MSG_OFF;
          res.msg_length = elen - bsde_pkg::HDR_BYTES;
          res.last       = (elem_off_d == elen);
        end
      end

      // final payload byte with no match seen
      if (!res_valid && !match_found_d && (pos_p1 == {1'b0, packet_length_i})) begin
        res_valid = 1'b1;
        res.kind  = bsde_pkg::KIND_NO_MATCH;
        res.last  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q     <= '0;
      next_start_q   <= '0;
      elem_len_q     <= '0;
      elem_off_q     <= '0;
      hdr_match_q    <= 1'b0;
      match_found_q  <= 1'b0;
      walk_stopped_q <= 1'b0;
    end else if (in_fire) begin
      byte_pos_q     <= byte_pos_d;
      next_start_q   <= next_start_d;
      elem_len_q     <= elem_len_d;
      elem_off_q     <= elem_off_d;
      hdr_match_q    <= hdr_match_d;
      match_found_q  <= match_found_d;
      walk_stopped_q <= walk_stopped_d;
    end
  end

  // ------------------------------------------------------------------
  // Output register plus skid register
  // ------------------------------------------------------------------
  logic              out_valid_q;
  bsde_pkg::result_t out_q;
  logic              skid_valid_q;
  bsde_pkg::result_t skid_q;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // input is stalled; drain the skid entry first
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= in_fire && res_valid;
    end else if (in_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_fire) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.kind;
  assign message_byte_o   = out_q.msg_byte;
  assign message_index_o  = out_q.msg_index;
  assign message_length_o = out_q.msg_length;
  assign last_of_run_o    = out_q.last;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_match_xor_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(match_found_q && walk_stopped_q))
    else $error("walk stopped after a match");

  a_msg_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o == bsde_pkg::KIND_MSG_BYTE))
      |-> (message_index_o < message_length_o))
    else $error("message index past message length");

  a_last_on_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o != bsde_pkg::KIND_MSG_BYTE))
      |-> (last_of_run_o && (message_byte_o == 8'd0) && (message_index_o == 8'd0)))
    else $error("summary result malformed");

  a_offset_in_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_off_q <= elem_len_q)
    else $error("element offset past element length");

endmodule

`default_nettype wire
